[rtl/core/afc_pkg.sv]
// shared types and constants for the arq frame classifier
`default_nettype none
package afc_pkg;

	typedef enum logic [2:0] {
		KIND_CONTENT     = 3'd0,
		KIND_META        = 3'd1,
		KIND_CONTENT_ACK = 3'd2,
		KIND_META_ACK    = 3'd3,
		KIND_EOF         = 3'd4,
		KIND_SPREAD      = 3'd5,
		KIND_BANDWIDTH   = 3'd6,
		KIND_SFBW_ACK    = 3'd7
	} frame_kind_t;

	typedef enum logic [2:0] {
		ACK_NONE    = 3'd0,
		ACK_CONTENT = 3'd1,
		ACK_META    = 3'd2,
		ACK_SPREAD  = 3'd3,
		ACK_BW      = 3'd4
	} peer_ack_t;

	localparam logic [7:0]  HDR_CONTENT_ACK = 8'h40;
	localparam logic [7:0]  HDR_META_ACK    = 8'h60;
	localparam logic [7:0]  HDR_ECHO        = 8'hE0;
	localparam logic [15:0] NUMBER_NONE     = 16'hFFFF;
	localparam logic [7:0]  LEN_CONTENT_ACK = 8'd3;
	localparam logic [7:0]  LEN_META_ACK    = 8'd1;
	localparam logic [7:0]  LEN_SPREAD_ECHO = 8'd2;
	localparam logic [7:0]  LEN_MIN_ACK     = 8'd3;

	typedef struct packed {
		logic [7:0] header_byte;
		logic [7:0] field_high;
		logic [7:0] field_low;
		logic [7:0] frame_length;
	} frame_item_t;

	typedef struct packed {
		logic        accepted;
		logic        store_payload;
		logic [7:0]  reply_length;
		logic [7:0]  reply_header;
		logic [15:0] reply_number;
		logic        start_file;
		logic [15:0] packet_total;
		logic        end_file;
		logic        set_spread;
		logic        set_bandwidth;
		logic [2:0]  peer_ack;
		logic [15:0] peer_value;
	} result_item_t;

	typedef struct packed {
		logic        metadata_seen;
		logic [15:0] last_packet_number;
	} link_ctx_t;

endpackage
`default_nettype wire

[rtl/core/afc_if.sv]
// valid/ready channel interfaces for frame headers and classification results
`default_nettype none
interface afc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] header_byte;
	logic [7:0] field_high;
	logic [7:0] field_low;
	logic [7:0] frame_length;

	modport source (output valid, header_byte, field_high, field_low, frame_length,
		input ready);
	modport sink (input valid, header_byte, field_high, field_low, frame_length,
		output ready);
endinterface

interface afc_out_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic        store_payload;
	logic [7:0]  reply_length;
	logic [7:0]  reply_header;
	logic [15:0] reply_number;
	logic        start_file;
	logic [15:0] packet_total;
	logic        end_file;
	logic        set_spread;
	logic        set_bandwidth;
	logic [2:0]  peer_ack;
	logic [15:0] peer_value;

	modport source (output valid, accepted, store_payload, reply_length, reply_header,
		reply_number, start_file, packet_total, end_file, set_spread, set_bandwidth,
		peer_ack, peer_value, input ready);
	modport sink (input valid, accepted, store_payload, reply_length, reply_header,
		reply_number, start_file, packet_total, end_file, set_spread, set_bandwidth,
		peer_ack, peer_value, output ready);
endinterface
`default_nettype wire

[rtl/core/afc_classify.sv]
// frame type decode, duplicate check and reply selection
`default_nettype none
module afc_classify (
	input  wire afc_pkg::frame_item_t  item,
	input  wire afc_pkg::link_ctx_t    ctx,
	output afc_pkg::result_item_t res,
	output afc_pkg::link_ctx_t    ctx_next
);

	logic [15:0]          number;
	afc_pkg::frame_kind_t kind;

	assign number = {item.field_high, item.field_low};
	assign kind   = afc_pkg::frame_kind_t'(item.header_byte[7:5]);

	always_comb begin
		res      = '0;
		ctx_next = ctx;
		if (item.frame_length != 8'd0) begin
			case (kind)
				afc_pkg::KIND_CONTENT: begin
					if (ctx.metadata_seen) begin
						res.accepted     = 1'b1;
						res.reply_length = afc_pkg::LEN_CONTENT_ACK;
						res.reply_header = afc_pkg::HDR_CONTENT_ACK;
						res.reply_number = number;
						// a repeat of the last number is acked but not stored
						if (number != ctx.last_packet_number) begin
							res.store_payload           = 1'b1;
							ctx_next.last_packet_number = number;
						end
					end
				end
				afc_pkg::KIND_META: begin
					ctx_next.metadata_seen      = 1'b1;
					ctx_next.last_packet_number = '0;
					res.accepted     = 1'b1;
					res.reply_length = afc_pkg::LEN_META_ACK;
					res.reply_header = afc_pkg::HDR_META_ACK;
					res.start_file   = 1'b1;
					res.packet_total = number;
				end
				afc_pkg::KIND_CONTENT_ACK: begin
					if (item.frame_length >= afc_pkg::LEN_MIN_ACK) begin
						res.accepted   = 1'b1;
						res.peer_ack   = afc_pkg::ACK_CONTENT;
						res.peer_value = number;
					end
				end
				afc_pkg::KIND_META_ACK: begin
					res.accepted = 1'b1;
					res.peer_ack = afc_pkg::ACK_META;
				end
				afc_pkg::KIND_EOF: begin
					ctx_next.metadata_seen      = 1'b0;
					ctx_next.last_packet_number = afc_pkg::NUMBER_NONE;
					res.accepted = 1'b1;
					res.end_file = 1'b1;
				end
				afc_pkg::KIND_SPREAD: begin
					res.accepted     = 1'b1;
					res.reply_length = afc_pkg::LEN_SPREAD_ECHO;
					res.reply_header = afc_pkg::HDR_ECHO;
					res.reply_number = {item.field_high, 8'd0};
					res.set_spread   = 1'b1;
				end
				afc_pkg::KIND_BANDWIDTH: begin
					res.accepted      = 1'b1;
					res.reply_length  = item.frame_length;
					res.reply_header  = afc_pkg::HDR_ECHO;
					res.reply_number  = number;
					res.set_bandwidth = 1'b1;
				end
				afc_pkg::KIND_SFBW_ACK: begin
					res.accepted = 1'b1;
					if (item.frame_length > afc_pkg::LEN_SPREAD_ECHO) begin
						res.peer_ack = afc_pkg::ACK_BW;
					end else begin
						res.peer_ack   = afc_pkg::ACK_SPREAD;
						res.peer_value = {8'd0, item.field_high};
					end
				end
				default: begin
					res = '0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/core/afc_state.sv]
// link state register: metadata flag and last stored packet number
`default_nettype none
module afc_state (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic update,
	input  wire afc_pkg::link_ctx_t ctx_next,
	output afc_pkg::link_ctx_t ctx
);

	afc_pkg::link_ctx_t ctx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.metadata_seen      <= 1'b0;
			ctx_q.last_packet_number <= afc_pkg::NUMBER_NONE;
		end else if (update) begin
			ctx_q <= ctx_next;
		end
	end

	assign ctx = ctx_q;

endmodule
`default_nettype wire

[rtl/core/arq_frame_classifier.sv]
// top level of the arq frame classifier: input register, decode, result register
`default_nettype none
// Receive-side frame classifier for a stop-and-wait ARQ file link. Each
// transfer on frame carries the first three bytes and the total length of
// one received radio frame; each brings exactly one transfer on result, in
// order. Bits 7..5 of the header byte pick the frame type. Content frames
// are refused until a metadata frame has been seen; a content frame that
// repeats the last stored number is acked again but store_payload stays low.
// A metadata frame restarts numbering at zero, an end-of-file frame drops
// the metadata flag and sets the last number to all ones. Spreading factor
// and bandwidth frames are echoed with header 0xE0, and acks from the peer
// are reported on peer_ack/peer_value. An empty frame gives an all-zero
// result and leaves the state alone. Throughput is one frame per clock while
// result.ready does not hold the result stage: there is one input register
// stage and one result register, and the link state is read and written
// once per frame in the decode between them. Result valid rises once the
// frame has passed the input register and then the result register.
// frame.ready follows result.ready through the two stages; while the result
// stage holds a frame, one more is still taken into the input stage.
module arq_frame_classifier (
	input wire logic   clk,
	input wire logic   arst_n,
	afc_in_if.sink     frame,
	afc_out_if.source  result
);

	// stage 1: registered frame header
	logic                  valid_s1;
	afc_pkg::frame_item_t  item_s1;

	// stage 2: registered result
	logic                  valid_s2;
	afc_pkg::result_item_t res_s2;

	afc_pkg::result_item_t res_comb;
	afc_pkg::link_ctx_t    ctx;
	afc_pkg::link_ctx_t    ctx_next;

	logic s2_free;
	logic move;
	logic take;

	// result stage can load when empty or when its transfer completes now
	assign s2_free     = !valid_s2 || result.ready;
	assign move        = valid_s1 && s2_free;
	assign frame.ready = !valid_s1 || s2_free;
	assign take        = frame.valid && frame.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.header_byte  <= frame.header_byte;
			item_s1.field_high   <= frame.field_high;
			item_s1.field_low    <= frame.field_low;
			item_s1.frame_length <= frame.frame_length;
		end
	end

	afc_classify u_classify (
		.item     (item_s1),
		.ctx      (ctx),
		.res      (res_comb),
		.ctx_next (ctx_next)
	);

	// state advances exactly when a frame leaves stage 1
	afc_state u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.update   (move),
		.ctx_next (ctx_next),
		.ctx      (ctx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (move) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			res_s2 <= res_comb;
		end
	end

	assign result.valid         = valid_s2;
	assign result.accepted      = res_s2.accepted;
	assign result.store_payload = res_s2.store_payload;
	assign result.reply_length  = res_s2.reply_length;
	assign result.reply_header  = res_s2.reply_header;
	assign result.reply_number  = res_s2.reply_number;
	assign result.start_file    = res_s2.start_file;
	assign result.packet_total  = res_s2.packet_total;
	assign result.end_file      = res_s2.end_file;
	assign result.set_spread    = res_s2.set_spread;
	assign result.set_bandwidth = res_s2.set_bandwidth;
	assign result.peer_ack      = res_s2.peer_ack;
	assign result.peer_value    = res_s2.peer_value;

`ifndef SYNTHESIS
	// end of file always leaves the link with no metadata and no last number
	a_eof_clears: assert property (@(posedge clk) disable iff (!arst_n)
		move && res_comb.end_file |=>
			!ctx.metadata_seen && ctx.last_packet_number == afc_pkg::NUMBER_NONE)
		else $error("end-of-file did not clear link state");

	// a stored payload is always an accepted, acked content frame
	a_store_acked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.store_payload |->
			res_s2.accepted && res_s2.reply_header == afc_pkg::HDR_CONTENT_ACK)
		else $error("stored payload without content ack");

	// a refused frame carries no reply and no side effect
	a_refused_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.accepted |->
			res_s2.reply_length == 8'd0 && res_s2.peer_ack == afc_pkg::ACK_NONE
			&& !res_s2.start_file && !res_s2.end_file)
		else $error("refused frame has reply or side effect");

	// content accepted only with metadata seen
	a_content_needs_meta: assert property (@(posedge clk) disable iff (!arst_n)
		move && res_comb.store_payload |-> ctx.metadata_seen)
		else $error("content stored before metadata");
`endif

endmodule
`default_nettype wire
